// ===== hw/rtl/owm_pkg.sv =====
// Shared types, constants and register indexes of the 1-Wire bus master.
package owm_pkg;

   localparam int unsigned TickW = 10;
   localparam int unsigned CsrIndexW = 3;
   localparam int unsigned CsrDataW = 10;

   localparam logic [CsrIndexW-1:0] CSR_RESET_LOW = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_PRESENCE_SAMPLE = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_RESET_RECOVERY = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_SLOT_RELEASE = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_SLOT_SAMPLE = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_SLOT_LENGTH = 3'd5;

   localparam logic [2:0] OP_RESET = 3'd0;
   localparam logic [2:0] OP_BIT = 3'd1;
   localparam logic [2:0] OP_BYTE = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ = 3'd4;
   localparam logic [2:0] OP_WRITE_POWER = 3'd5;
   localparam logic [2:0] OP_READBIT_POWER = 3'd6;
   localparam logic [2:0] OP_LEVEL = 3'd7;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [TickW-1:0] RESET_LOW_DEFAULT = 10'd480;
   localparam logic [TickW-1:0] PRESENCE_SAMPLE_DEFAULT = 10'd70;
   localparam logic [TickW-1:0] RESET_RECOVERY_DEFAULT = 10'd480;
   localparam logic [3:0] SLOT_RELEASE_DEFAULT = 4'd1;
   localparam logic [5:0] SLOT_SAMPLE_DEFAULT = 6'd15;
   localparam logic [6:0] SLOT_LENGTH_DEFAULT = 7'd60;
   localparam logic [7:0] READ_PATTERN = 8'hFF;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_RST_LOW  = 6'b000010,
      PH_RST_WAIT = 6'b000100,
      PH_RST_REC  = 6'b001000,
      PH_SLOT     = 6'b010000,
      PH_GAP      = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [TickW-1:0] reset_low_us;
      logic [TickW-1:0] presence_sample_us;
      logic [TickW-1:0] reset_recovery_us;
      logic [3:0]       slot_release_us;
      logic [5:0]       slot_sample_us;
      logic [6:0]       slot_length_us;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] op;
      logic [7:0] data_byte;
      logic       expect_bit;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic       drive_low;
      logic       strong_pullup;
      logic       busy_res;
      logic       done_res;
      logic       rejected;
      logic [7:0] read_data;
      logic       ok;
   } result_type;

endpackage

// ===== hw/rtl/one_wire_bus_master.sv =====
// Top level of the standard-speed 1-Wire bus master with its request and result registers.
//
//   Channel   Direction  Handshake            Contents
//   req_*     in         req_valid/req_stall  command or one-microsecond tick with line level
//   rsp_*     out        rsp_valid/rsp_stall  bus drive, busy, done, rejected, data, ok
//   csr_*     in         csr_write_en         timing register writes, no read-back
//
// A request is resolved by the engine while it sits in the input register, and its result
// is registered when the request advances, which waits while a stalled result is held.
// Absent rsp_stall, one request per cycle is sustained by combinational next-state logic.
// Reset is synchronous and returns the engine to idle with the default timing.
// A stalled result holds the result register, and the input register then holds too.
module one_wire_bus_master (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [2:0]                    req_op,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_expect_bit,
   input  logic                          req_line_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_drive_low,
   output logic                          rsp_strong_pullup,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic                          rsp_rejected,
   output logic [7:0]                    rsp_read_data,
   output logic                          rsp_ok,
   input  logic                          csr_write_en,
   input  logic [owm_pkg::CsrIndexW-1:0] csr_index,
   input  logic [owm_pkg::CsrDataW-1:0]  csr_write_data
);
   import owm_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   result_type result;
   result_type result_ff;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       take;

   owm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   owm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign take = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.kind <= req_kind;
         item_ff.op <= req_op;
         item_ff.data_byte <= req_data_byte;
         item_ff.expect_bit <= req_expect_bit;
         item_ff.line_level <= req_line_level;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_drive_low = result_ff.drive_low;
   assign rsp_strong_pullup = result_ff.strong_pullup;
   assign rsp_busy_res = result_ff.busy_res;
   assign rsp_done_res = result_ff.done_res;
   assign rsp_rejected = result_ff.rejected;
   assign rsp_read_data = result_ff.read_data;
   assign rsp_ok = result_ff.ok;

   // The input register only pushes back when it is full behind a stalled result.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled without a full pipeline");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_rejected)
      else $error("finished result still busy or rejected");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_done_res |-> (rsp_read_data == 8'd0) && !rsp_ok)
      else $error("data or ok reported without completion");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> !(rsp_drive_low && rsp_strong_pullup))
      else $error("bus driven low and strongly high together");

   assert property (@(posedge clock) disable iff (reset)
                    advance && out_valid_ff && rsp_stall |-> 1'b0)
      else $error("result register overwritten while stalled");

endmodule

// ===== hw/rtl/owm_csr.sv =====
// Timing configuration registers of the 1-Wire bus master.
module owm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [owm_pkg::CsrIndexW-1:0] csr_index,
   input  logic [owm_pkg::CsrDataW-1:0]  csr_write_data,
   output owm_pkg::cfg_type              cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RESET_LOW:       cfg_in.reset_low_us = csr_write_data;
            CSR_PRESENCE_SAMPLE: cfg_in.presence_sample_us = csr_write_data;
            CSR_RESET_RECOVERY:  cfg_in.reset_recovery_us = csr_write_data;
            CSR_SLOT_RELEASE:    cfg_in.slot_release_us = csr_write_data[3:0];
            CSR_SLOT_SAMPLE:     cfg_in.slot_sample_us = csr_write_data[5:0];
            CSR_SLOT_LENGTH:     cfg_in.slot_length_us = csr_write_data[6:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us <= RESET_LOW_DEFAULT;
         cfg_ff.presence_sample_us <= PRESENCE_SAMPLE_DEFAULT;
         cfg_ff.reset_recovery_us <= RESET_RECOVERY_DEFAULT;
         cfg_ff.slot_release_us <= SLOT_RELEASE_DEFAULT;
         cfg_ff.slot_sample_us <= SLOT_SAMPLE_DEFAULT;
         cfg_ff.slot_length_us <= SLOT_LENGTH_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/owm_engine.sv =====
// Bus state registers and the per-request next-state and result logic.
module owm_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  owm_pkg::item_type   item,
   input  owm_pkg::cfg_type    cfg,
   output owm_pkg::result_type result
);
   import owm_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [TickW-1:0] tick_count_ff, tick_count_in;
   logic [2:0]       bit_index_ff, bit_index_in;
   logic [7:0]       send_shift_ff, send_shift_in;
   logic [7:0]       recv_shift_ff, recv_shift_in;
   logic [2:0]       current_op_ff, current_op_in;
   logic             saved_expect_ff, saved_expect_in;
   logic             presence_fail_ff, presence_fail_in;
   logic             pull_low_ff, pull_low_in;
   logic             pullup_on_ff, pullup_on_in;

   always_comb begin
      logic [TickW-1:0] tick_inc;
      logic [TickW-1:0] low_lim;
      logic [TickW-1:0] wait_lim;
      logic [TickW-1:0] rec_lim;
      logic [6:0]       len;
      logic [6:0]       smp;
      logic             sbit;
      logic [7:0]       recv_next;
      logic             single;
      logic             done;
      logic             rej;
      logic [7:0]       rdata;
      logic             okv;

      phase_in = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in = bit_index_ff;
      send_shift_in = send_shift_ff;
      recv_shift_in = recv_shift_ff;
      current_op_in = current_op_ff;
      saved_expect_in = saved_expect_ff;
      presence_fail_in = presence_fail_ff;
      pull_low_in = pull_low_ff;
      pullup_on_in = pullup_on_ff;
      done = 1'b0;
      rej = 1'b0;
      rdata = 8'd0;
      okv = 1'b0;

      tick_inc = tick_count_ff + 10'd1;
      low_lim = (cfg.reset_low_us == '0) ? 10'd1 : cfg.reset_low_us;
      wait_lim = (cfg.presence_sample_us == '0) ? 10'd1 : cfg.presence_sample_us;
      rec_lim = (cfg.reset_recovery_us == '0) ? 10'd1 : cfg.reset_recovery_us;
      len = (cfg.slot_length_us == '0) ? 7'd1 : cfg.slot_length_us;
      if ({1'b0, cfg.slot_sample_us} > len) begin
         smp = len;
      end else if (cfg.slot_sample_us == '0) begin
         smp = 7'd1;
      end else begin
         smp = {1'b0, cfg.slot_sample_us};
      end
      sbit = send_shift_ff[bit_index_ff];
      recv_next = recv_shift_ff;
      if (tick_inc == {3'd0, smp}) begin
         recv_next[bit_index_ff] = recv_shift_ff[bit_index_ff] | (sbit & item.line_level);
      end
      single = (current_op_ff == OP_BIT) || (current_op_ff == OP_READBIT_POWER);

      if (item.kind == KIND_COMMAND) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else if (item.op == OP_LEVEL) begin
            pullup_on_in = item.data_byte[0];
            pull_low_in = 1'b0;
            done = 1'b1;
            rdata = {7'd0, item.data_byte[0]};
            okv = 1'b1;
         end else begin
            pullup_on_in = 1'b0;
            pull_low_in = 1'b1;
            tick_count_in = '0;
            current_op_in = item.op;
            if (item.op == OP_RESET) begin
               phase_in = PH_RST_LOW;
               presence_fail_in = 1'b0;
            end else begin
               phase_in = PH_SLOT;
               bit_index_in = 3'd0;
               recv_shift_in = 8'd0;
               saved_expect_in = item.expect_bit;
               case (item.op)
                  OP_BIT:           send_shift_in = {7'd0, item.data_byte[0]};
                  OP_READ:          send_shift_in = READ_PATTERN;
                  OP_READBIT_POWER: send_shift_in = 8'd1;
                  default:          send_shift_in = item.data_byte;
               endcase
            end
         end
      end else begin
         case (phase_ff)
            PH_RST_LOW: begin
               tick_count_in = tick_inc;
               if (tick_inc >= low_lim) begin
                  pull_low_in = 1'b0;
                  phase_in = PH_RST_WAIT;
                  tick_count_in = '0;
               end
            end
            PH_RST_WAIT: begin
               tick_count_in = tick_inc;
               if (tick_inc >= wait_lim) begin
                  presence_fail_in = item.line_level;
                  phase_in = PH_RST_REC;
                  tick_count_in = '0;
               end
            end
            PH_RST_REC: begin
               tick_count_in = tick_inc;
               if (tick_inc >= rec_lim) begin
                  presence_fail_in = presence_fail_ff | ~item.line_level;
                  phase_in = PH_IDLE;
                  tick_count_in = '0;
                  done = 1'b1;
                  okv = ~(presence_fail_ff | ~item.line_level);
               end
            end
            PH_GAP: begin
               pull_low_in = 1'b1;
               tick_count_in = '0;
               phase_in = PH_SLOT;
            end
            PH_SLOT: begin
               tick_count_in = tick_inc;
               recv_shift_in = recv_next;
               if (sbit && (tick_inc >= {6'd0, cfg.slot_release_us})) begin
                  pull_low_in = 1'b0;
               end
               if (tick_inc >= {3'd0, len}) begin
                  pull_low_in = 1'b0;
                  tick_count_in = '0;
                  if (single || (bit_index_ff == 3'd7)) begin
                     phase_in = PH_IDLE;
                     done = 1'b1;
                     okv = 1'b1;
                     rdata = single ? {7'd0, recv_next[0]} : recv_next;
                     if ((current_op_ff == OP_WRITE) || (current_op_ff == OP_WRITE_POWER)) begin
                        okv = (recv_next == send_shift_ff);
                     end
                     if (current_op_ff == OP_READBIT_POWER) begin
                        okv = (recv_next[0] == saved_expect_ff);
                     end
                     if (((current_op_ff == OP_WRITE_POWER) ||
                          (current_op_ff == OP_READBIT_POWER)) && okv) begin
                        pullup_on_in = 1'b1;
                     end
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in = PH_GAP;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end

      result.drive_low = pull_low_in;
      result.strong_pullup = pullup_on_in;
      result.busy_res = (phase_in != PH_IDLE);
      result.done_res = done;
      result.rejected = rej;
      result.read_data = rdata;
      result.ok = okv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff <= '0;
         send_shift_ff <= '0;
         recv_shift_ff <= '0;
         current_op_ff <= '0;
         saved_expect_ff <= 1'b0;
         presence_fail_ff <= 1'b0;
         pull_low_ff <= 1'b0;
         pullup_on_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff <= bit_index_in;
         send_shift_ff <= send_shift_in;
         recv_shift_ff <= recv_shift_in;
         current_op_ff <= current_op_in;
         saved_expect_ff <= saved_expect_in;
         presence_fail_ff <= presence_fail_in;
         pull_low_ff <= pull_low_in;
         pullup_on_ff <= pullup_on_in;
      end
   end

endmodule
